// ----- design/texture_sampler_wrap_filter_defines.svh -----
// ----------------------------------------------------------------------------
// Texture sampler assertion macros
// Concurrent check wrappers, active in simulation and empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef TEXTURE_SAMPLER_WRAP_FILTER_DEFINES_SVH
`define TEXTURE_SAMPLER_WRAP_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
// Property that holds at every edge out of reset
`define TSWF_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent
`define TSWF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TSWF_ASSERT_ALWAYS(lbl, expr, msg)
`define TSWF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- design/tswf_pkg.sv -----
// ----------------------------------------------------------------------------
// Texture sampler package
// Shared widths, codes and beat structures of the texture sampler.
// ----------------------------------------------------------------------------
package tswf_pkg;

  localparam int COORD_W     = 24;
  localparam int TEXEL_W     = 24;
  localparam int IDX_W       = 16;
  localparam int CHAN_W      = 16;
  localparam int SIZE_W      = 9;
  localparam int CFG_IDX_W   = 3;
  localparam int STORE_DEPTH = 65536;

  // item kinds
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // filter codes
  localparam logic FILTER_NEAREST = 1'b0;

  // wrap codes (none and unused code fall to default)
  localparam logic [1:0] WRAP_REPEAT = 2'd1;
  localparam logic [1:0] WRAP_CLAMP  = 2'd2;

  // texture environment codes
  localparam logic [1:0] ENV_MODULATE = 2'd1;
  localparam logic [1:0] ENV_REPLACE  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_S = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_T = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENV    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd5;

  typedef struct packed {
    logic              filter_mode;
    logic [1:0]        wrap_s_mode;
    logic [1:0]        wrap_t_mode;
    logic [1:0]        env_mode;
    logic [SIZE_W-1:0] tex_width;
    logic [SIZE_W-1:0] tex_height;
  } cfg_t;

  typedef struct packed {
    logic               action;
    logic [IDX_W-1:0]   texel_index;
    logic [TEXEL_W-1:0] texel;
    logic [COORD_W-1:0] coord_s;
    logic [COORD_W-1:0] coord_t;
    logic [CHAN_W-1:0]  frag_red;
    logic [CHAN_W-1:0]  frag_green;
    logic [CHAN_W-1:0]  frag_blue;
  } item_t;

  // fetch request leaving the address stage
  typedef struct packed {
    logic               valid;
    logic               action;
    logic               neg;
    logic [IDX_W-1:0]   texel_index;
    logic [TEXEL_W-1:0] texel;
    logic [CHAN_W-1:0]  frag_red;
    logic [CHAN_W-1:0]  frag_green;
    logic [CHAN_W-1:0]  frag_blue;
    logic [15:0]        ds;
    logic [15:0]        dt;
    logic [IDX_W-1:0]   addr_ll;
    logic [IDX_W-1:0]   addr_lr;
    logic [IDX_W-1:0]   addr_ul;
    logic [IDX_W-1:0]   addr_ur;
  } fetch_t;

  typedef struct packed {
    logic              valid;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              textured;
  } result_t;

endpackage

// ----- design/texture_sampler_wrap_filter.sv -----
// ----------------------------------------------------------------------------
// Texture sampler with wrap modes, bilinear filter and environment stage
// Top level: configuration registers, input stage, texel store, output queue.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries write beats, which store one RGB
// texel and return nothing, and sample beats, which return one colored beat
// on the output channel (out_valid/out_ready) in the same order.
// Configuration beats (cfg_valid/cfg_ready, always ready) set one register
// each; the user must send them only while no item is in flight (unchecked).
// Throughput is one beat per cycle while the output queue has room. A sample
// result passes the coordinate, read and filter registers into the output
// queue. The rate is set by the texel store: two copies with two read ports
// each serve all four bilinear reads of a sample; every write goes to both.
// A write reaches the store in the same stage where later samples read, so
// reads always see earlier writes.
// Reset clears the registers to nearest filter, no wrap, pass-through and a
// 256 by 256 texture. The store is not cleared; unwritten texels read as
// unknown.
// When the receiver stalls, results collect in a two-entry queue; once it is
// full the whole pipeline holds and in_ready drops.
// ----------------------------------------------------------------------------
`include "texture_sampler_wrap_filter_defines.svh"

module texture_sampler_wrap_filter #(
  parameter int MAX_DIM         = 256,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              action,
  input  logic [tswf_pkg::IDX_W-1:0]        texel_index,
  input  logic [7:0]                        texel_red,
  input  logic [7:0]                        texel_green,
  input  logic [7:0]                        texel_blue,
  input  logic signed [tswf_pkg::COORD_W-1:0] coord_s,
  input  logic signed [tswf_pkg::COORD_W-1:0] coord_t,
  input  logic [tswf_pkg::CHAN_W-1:0]       frag_red,
  input  logic [tswf_pkg::CHAN_W-1:0]       frag_green,
  input  logic [tswf_pkg::CHAN_W-1:0]       frag_blue,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tswf_pkg::CHAN_W-1:0]       out_red,
  output logic [tswf_pkg::CHAN_W-1:0]       out_green,
  output logic [tswf_pkg::CHAN_W-1:0]       out_blue,
  output logic                              textured,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tswf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tswf_pkg::SIZE_W-1:0]       cfg_data
);

  tswf_pkg::cfg_t    cfg;
  tswf_pkg::item_t   a_item;
  tswf_pkg::fetch_t  fetch;
  tswf_pkg::result_t res;
  logic              a_valid;
  logic              en;
  logic [1:0]        ocount;
  logic              rd_ptr, wr_ptr;
  logic              push, pop;
  tswf_pkg::result_t oq [2];
  logic [tswf_pkg::TEXEL_W-1:0] tx_ll, tx_lr, tx_ul, tx_ur;
  logic              store_we;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_mode <= tswf_pkg::FILTER_NEAREST;
      cfg.wrap_s_mode <= '0;
      cfg.wrap_t_mode <= '0;
      cfg.env_mode    <= '0;
      cfg.tex_width   <= 9'd256;
      cfg.tex_height  <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tswf_pkg::CFG_FILTER: cfg.filter_mode <= cfg_data[0];
        tswf_pkg::CFG_WRAP_S: cfg.wrap_s_mode <= cfg_data[1:0];
        tswf_pkg::CFG_WRAP_T: cfg.wrap_t_mode <= cfg_data[1:0];
        tswf_pkg::CFG_ENV:    cfg.env_mode    <= cfg_data[1:0];
        tswf_pkg::CFG_WIDTH:  cfg.tex_width   <= cfg_data;
        tswf_pkg::CFG_HEIGHT: cfg.tex_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advances while the output queue has room
  assign en       = (ocount != 2'd2);
  assign in_ready = en;

  // stage A: input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_item.action      <= action;
      a_item.texel_index <= texel_index;
      a_item.texel       <= {texel_red, texel_green, texel_blue};
      a_item.coord_s     <= coord_s;
      a_item.coord_t     <= coord_t;
      a_item.frag_red    <= frag_red;
      a_item.frag_green  <= frag_green;
      a_item.frag_blue   <= frag_blue;
    end
  end

  tswf_coord #(
    .MAX_DIM         (MAX_DIM),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_coord (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .a_valid (a_valid),
    .a_item  (a_item),
    .cfg     (cfg),
    .fetch   (fetch)
  );

  // texel store: two copies, written together, two reads each
  assign store_we = en && fetch.valid && (fetch.action == tswf_pkg::ACT_WRITE);

  tswf_ram #(
    .WIDTH (tswf_pkg::TEXEL_W),
    .DEPTH (tswf_pkg::STORE_DEPTH)
  ) u_store_lo (
    .clk     (clk),
    .we      (store_we),
    .waddr   (fetch.texel_index),
    .wdata   (fetch.texel),
    .re      (en),
    .raddr_a (fetch.addr_ll),
    .raddr_b (fetch.addr_lr),
    .rdata_a (tx_ll),
    .rdata_b (tx_lr)
  );

  tswf_ram #(
    .WIDTH (tswf_pkg::TEXEL_W),
    .DEPTH (tswf_pkg::STORE_DEPTH)
  ) u_store_hi (
    .clk     (clk),
    .we      (store_we),
    .waddr   (fetch.texel_index),
    .wdata   (fetch.texel),
    .re      (en),
    .raddr_a (fetch.addr_ul),
    .raddr_b (fetch.addr_ur),
    .rdata_a (tx_ul),
    .rdata_b (tx_ur)
  );

  tswf_filter u_filter (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .fetch    (fetch),
    .tx_ll    (tx_ll),
    .tx_lr    (tx_lr),
    .tx_ul    (tx_ul),
    .tx_ur    (tx_ur),
    .env_mode (cfg.env_mode),
    .res      (res)
  );

  // two-entry output queue
  assign push = en && res.valid;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ocount <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      ocount <= ocount + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      oq[wr_ptr] <= res;
    end
  end

  assign out_valid = (ocount != 2'd0);
  assign out_red   = oq[rd_ptr].red;
  assign out_green = oq[rd_ptr].green;
  assign out_blue  = oq[rd_ptr].blue;
  assign textured  = oq[rd_ptr].textured;

  // checks
  `TSWF_ASSERT_ALWAYS(a_ocount_range, ocount <= 2'd2, "output queue count out of range")
  `TSWF_ASSERT_ALWAYS(a_no_push_full, !(push && (ocount == 2'd2)), "result pushed into full queue")
  `TSWF_ASSERT_NEXT(a_pop_drains, pop && !push, ocount == $past(ocount) - 2'd1, "queue count did not drop")

endmodule

// ----- design/tswf_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports, read data registered under read enable.
// ----------------------------------------------------------------------------
module tswf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- design/tswf_coord.sv -----
// ----------------------------------------------------------------------------
// Texture sampler coordinate stages
// Wrap and scale coordinates, pick texel indices and weights, form addresses.
// ----------------------------------------------------------------------------
module tswf_coord #(
  parameter int MAX_DIM         = 256,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                a_valid,
  input  tswf_pkg::item_t     a_item,
  input  tswf_pkg::cfg_t      cfg,
  output tswf_pkg::fetch_t    fetch
);

  localparam int CW   = tswf_pkg::COORD_W;
  localparam int SZW  = $clog2(MAX_DIM);
  localparam int DIMW = $clog2(MAX_DIM + 1);
  localparam int XW   = CW + 1;
  localparam int PW   = XW + SZW;
  localparam int IW   = PW + 1 - COORD_FRAC_BITS;
  localparam int AWF  = SZW + DIMW + 1;
  localparam int MW   = (AWF > tswf_pkg::IDX_W) ? AWF : tswf_pkg::IDX_W;
  localparam logic [XW-1:0] ONE   = XW'(1) << COORD_FRAC_BITS;
  localparam logic [XW-1:0] FMASK = ONE - XW'(1);
  localparam logic [PW:0]   HALF  = (PW + 1)'(1) << (COORD_FRAC_BITS - 1);

  function automatic logic [XW-1:0] wrap(input logic [CW-1:0] c, input logic [1:0] mode);
    logic [XW-1:0] v;
    v = {1'b0, c};
    case (mode)
      tswf_pkg::WRAP_REPEAT: v = v & FMASK;
      tswf_pkg::WRAP_CLAMP:  if (v > ONE) v = ONE;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [SZW-1:0] sat(input logic [IW-1:0] i, input logic [SZW-1:0] m1);
    return (i > IW'(m1)) ? m1 : SZW'(i);
  endfunction

  // effective sizes: zero acts as one, clamp at MAX_DIM
  logic [DIMW-1:0] w_eff, h_eff;
  logic [SZW-1:0]  w_m1, h_m1;

  always_comb begin
    if (cfg.tex_width == '0) begin
      w_eff = DIMW'(1);
    end else if (32'(cfg.tex_width) > 32'(MAX_DIM)) begin
      w_eff = DIMW'(MAX_DIM);
    end else begin
      w_eff = DIMW'(cfg.tex_width);
    end
    if (cfg.tex_height == '0) begin
      h_eff = DIMW'(1);
    end else if (32'(cfg.tex_height) > 32'(MAX_DIM)) begin
      h_eff = DIMW'(MAX_DIM);
    end else begin
      h_eff = DIMW'(cfg.tex_height);
    end
    w_m1 = SZW'(w_eff - DIMW'(1));
    h_m1 = SZW'(h_eff - DIMW'(1));
  end

  // stage B: wrapped coordinate times size minus one
  logic                b_valid;
  tswf_pkg::item_t     b_item;
  logic                b_neg;
  logic [PW-1:0]       b_ps, b_pt;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_item <= a_item;
      b_neg  <= a_item.coord_s[CW-1] | a_item.coord_t[CW-1];
      b_ps   <= PW'(wrap(a_item.coord_s, cfg.wrap_s_mode)) * PW'(w_m1);
      b_pt   <= PW'(wrap(a_item.coord_t, cfg.wrap_t_mode)) * PW'(h_m1);
    end
  end

  // stage C: texel indices and blend weights
  logic [IW-1:0]                  nx, ny, iu, iv;
  logic [COORD_FRAC_BITS+15:0]    fs_wide, ft_wide;
  logic [SZW-1:0]                 u0_next, u1_next, v0_next, v1_next;
  logic [15:0]                    ds_next, dt_next;

  always_comb begin
    nx      = IW'(({1'b0, b_ps} + HALF) >> COORD_FRAC_BITS);
    ny      = IW'(({1'b0, b_pt} + HALF) >> COORD_FRAC_BITS);
    iu      = IW'(b_ps >> COORD_FRAC_BITS);
    iv      = IW'(b_pt >> COORD_FRAC_BITS);
    fs_wide = {b_ps[COORD_FRAC_BITS-1:0], 16'h0000} >> COORD_FRAC_BITS;
    ft_wide = {b_pt[COORD_FRAC_BITS-1:0], 16'h0000} >> COORD_FRAC_BITS;
    if (cfg.filter_mode == tswf_pkg::FILTER_NEAREST) begin
      // one texel, zero weights reduce the blend to it
      u0_next = sat(nx, w_m1);
      u1_next = u0_next;
      v0_next = sat(ny, h_m1);
      v1_next = v0_next;
      ds_next = '0;
      dt_next = '0;
    end else begin
      u0_next = sat(iu, w_m1);
      u1_next = sat(iu + IW'(1), w_m1);
      v0_next = sat(iv, h_m1);
      v1_next = sat(iv + IW'(1), h_m1);
      ds_next = fs_wide[15:0];
      dt_next = ft_wide[15:0];
    end
  end

  logic            c_valid;
  tswf_pkg::item_t c_item;
  logic            c_neg;
  logic [SZW-1:0]  c_u0, c_u1, c_v0, c_v1;
  logic [15:0]     c_ds, c_dt;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_item <= b_item;
      c_neg  <= b_neg;
      c_u0   <= u0_next;
      c_u1   <= u1_next;
      c_v0   <= v0_next;
      c_v1   <= v1_next;
      c_ds   <= ds_next;
      c_dt   <= dt_next;
    end
  end

  // row-major addresses, modulo the store depth
  logic [MW-1:0] a_ll, a_lr, a_ul, a_ur;

  always_comb begin
    a_ll = MW'(c_u0) + MW'(c_v0) * MW'(w_eff);
    a_lr = MW'(c_u1) + MW'(c_v0) * MW'(w_eff);
    a_ul = MW'(c_u0) + MW'(c_v1) * MW'(w_eff);
    a_ur = MW'(c_u1) + MW'(c_v1) * MW'(w_eff);
  end

  always_comb begin
    fetch.valid       = c_valid;
    fetch.action      = c_item.action;
    fetch.neg         = c_neg;
    fetch.texel_index = c_item.texel_index;
    fetch.texel       = c_item.texel;
    fetch.frag_red    = c_item.frag_red;
    fetch.frag_green  = c_item.frag_green;
    fetch.frag_blue   = c_item.frag_blue;
    fetch.ds          = c_ds;
    fetch.dt          = c_dt;
    fetch.addr_ll     = a_ll[tswf_pkg::IDX_W-1:0];
    fetch.addr_lr     = a_lr[tswf_pkg::IDX_W-1:0];
    fetch.addr_ul     = a_ul[tswf_pkg::IDX_W-1:0];
    fetch.addr_ur     = a_ur[tswf_pkg::IDX_W-1:0];
  end

endmodule

// ----- design/tswf_filter.sv -----
// ----------------------------------------------------------------------------
// Texture sampler filter and environment stages
// Bilinear blend of four texels, then pass, modulate or replace the color.
// ----------------------------------------------------------------------------
module tswf_filter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  tswf_pkg::fetch_t               fetch,
  input  logic [tswf_pkg::TEXEL_W-1:0]   tx_ll,
  input  logic [tswf_pkg::TEXEL_W-1:0]   tx_lr,
  input  logic [tswf_pkg::TEXEL_W-1:0]   tx_ul,
  input  logic [tswf_pkg::TEXEL_W-1:0]   tx_ur,
  input  logic [1:0]                     env_mode,
  output tswf_pkg::result_t              res
);

  // stage D: beat meta aligned with the read data
  logic              d_valid, d_neg;
  logic [2:0][15:0]  d_frag;
  logic [15:0]       d_ds, d_dt;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= fetch.valid && (fetch.action == tswf_pkg::ACT_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_neg  <= fetch.neg;
      d_frag <= {fetch.frag_red, fetch.frag_green, fetch.frag_blue};
      d_ds   <= fetch.ds;
      d_dt   <= fetch.dt;
    end
  end

  // horizontal blend per channel
  logic [16:0]       ds_inv;
  logic [2:0][31:0]  lo_next, hi_next;
  logic [15:0]       c_ll, c_lr, c_ul, c_ur;

  always_comb begin
    ds_inv = 17'h10000 - {1'b0, d_ds};
    for (int ch = 0; ch < 3; ch++) begin
      c_ll = {2{tx_ll[23-8*ch -: 8]}};
      c_lr = {2{tx_lr[23-8*ch -: 8]}};
      c_ul = {2{tx_ul[23-8*ch -: 8]}};
      c_ur = {2{tx_ur[23-8*ch -: 8]}};
      lo_next[2-ch] = 32'(c_ll) * 32'(ds_inv) + 32'(c_lr) * 32'(d_ds);
      hi_next[2-ch] = 32'(c_ul) * 32'(ds_inv) + 32'(c_ur) * 32'(d_ds);
    end
  end

  logic              e_valid, e_neg;
  logic [2:0][15:0]  e_frag;
  logic [15:0]       e_dt;
  logic [2:0][31:0]  e_lo, e_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_neg  <= d_neg;
      e_frag <= d_frag;
      e_dt   <= d_dt;
      e_lo   <= lo_next;
      e_hi   <= hi_next;
    end
  end

  // vertical blend, rounded half up to 16 bits
  logic [16:0]       dt_inv;
  logic [47:0]       acc;
  logic [2:0][15:0]  tex_next;

  always_comb begin
    dt_inv = 17'h10000 - {1'b0, e_dt};
    acc    = '0;
    for (int ch = 0; ch < 3; ch++) begin
      acc = 48'(e_lo[ch]) * 48'(dt_inv) + 48'(e_hi[ch]) * 48'(e_dt) + 48'h0000_8000_0000;
      tex_next[ch] = acc[47:32];
    end
  end

  logic              f_valid, f_neg;
  logic [2:0][15:0]  f_frag, f_tex;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_neg  <= e_neg;
      f_frag <= e_frag;
      f_tex  <= tex_next;
    end
  end

  // modulate product with rounding bias
  logic              g_valid, g_neg;
  logic [2:0][15:0]  g_frag, g_tex;
  logic [2:0][31:0]  g_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (en) begin
      g_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_neg  <= f_neg;
      g_frag <= f_frag;
      g_tex  <= f_tex;
      for (int ch = 0; ch < 3; ch++) begin
        g_prod[ch] <= 32'(f_frag[ch]) * 32'(f_tex[ch]) + 32'd32767;
      end
    end
  end

  // divide by 65535 through x + (x >> 16) + 1, then select the color
  logic [32:0]       qsum;
  logic [2:0][15:0]  col_next;

  always_comb begin
    qsum = '0;
    for (int ch = 0; ch < 3; ch++) begin
      qsum = 33'(g_prod[ch]) + 33'(g_prod[ch] >> 16) + 33'd1;
      case (env_mode)
        tswf_pkg::ENV_MODULATE: col_next[ch] = qsum[31:16];
        tswf_pkg::ENV_REPLACE:  col_next[ch] = g_tex[ch];
        default:                col_next[ch] = g_frag[ch];
      endcase
      if (g_neg) begin
        col_next[ch] = g_frag[ch];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.red      <= col_next[2];
      res.green    <= col_next[1];
      res.blue     <= col_next[0];
      res.textured <= ~g_neg;
    end
  end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// Texture sampler testbench
// Drives write and sample beats with random idling, tracks the texel store and
// the registers, and compares every colored beat with the predicted color.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic       FILTER_BILINEAR = 1'b1;
  localparam logic [1:0] WRAP_NONE       = 2'd0;
  localparam logic [1:0] WRAP_UNUSED     = 2'd3;
  localparam logic [1:0] ENV_PASS        = 2'd0;
  localparam logic [1:0] ENV_UNUSED      = 2'd3;
  localparam int         CYCLE_LIMIT     = 400000;
  localparam int         PHASES          = 14;
  localparam int         PHASE_BEATS     = 80;
  localparam int         DIR_ROWS        = 12;

  typedef struct {
    logic        act;
    logic [15:0] idx;
    logic [23:0] rgb;
    logic [23:0] s;
    logic [23:0] t;
    logic [15:0] fr;
    logic [15:0] fg;
    logic [15:0] fb;
  } beat_t;

  typedef struct {
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
    logic        tx;
  } color_t;

  typedef struct {
    beat_t  b;
    color_t want;
  } dir_row_t;

  logic clk, rst;
  logic in_valid, in_ready, action;
  logic [tswf_pkg::IDX_W-1:0] texel_index;
  logic [7:0] texel_red, texel_green, texel_blue;
  logic signed [tswf_pkg::COORD_W-1:0] coord_s, coord_t;
  logic [tswf_pkg::CHAN_W-1:0] frag_red, frag_green, frag_blue;
  logic out_valid, out_ready;
  logic [tswf_pkg::CHAN_W-1:0] out_red, out_green, out_blue;
  logic textured;
  logic cfg_valid, cfg_ready;
  logic [tswf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tswf_pkg::SIZE_W-1:0] cfg_data;

  texture_sampler_wrap_filter dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .texel_index(texel_index), .texel_red(texel_red), .texel_green(texel_green),
    .texel_blue(texel_blue), .coord_s(coord_s), .coord_t(coord_t),
    .frag_red(frag_red), .frag_green(frag_green), .frag_blue(frag_blue),
    .out_valid(out_valid), .out_ready(out_ready), .out_red(out_red),
    .out_green(out_green), .out_blue(out_blue), .textured(textured),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow of the block: registers and texel store
  logic        m_filter;
  logic [1:0]  m_wrap_s, m_wrap_t, m_env;
  logic [8:0]  m_width, m_height;
  logic [23:0] tex_mem [tswf_pkg::STORE_DEPTH];
  bit          tex_written [tswf_pkg::STORE_DEPTH];

  color_t pending_colors[$];
  int     mismatches, n_samples, n_writes, n_checked, n_cycles;
  bit     quiet, hold_req;
  int     hold_cnt;
  dir_row_t dir_tbl [DIR_ROWS];

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int unsigned eff_dim(logic [8:0] r);
    if (r == 9'd0) return 1;
    if (r > 9'd256) return 256;
    return r;
  endfunction

  // wrap then scale by size - 1, 16 fraction bits kept
  function automatic logic [63:0] wrap_scale(logic [23:0] c, logic [1:0] mode,
                                             int unsigned size);
    logic [63:0] v;
    v = {40'd0, c};
    if (mode == tswf_pkg::WRAP_REPEAT) v = v & 64'hFFFF;
    else if (mode == tswf_pkg::WRAP_CLAMP && v > 64'h10000) v = 64'h10000;
    return v * (size - 1);
  endfunction

  function automatic int unsigned clip_idx(logic [63:0] i, int unsigned size);
    return (i > size - 1) ? size - 1 : int'(i);
  endfunction

  function automatic logic [15:0] store_addr(int unsigned x, int unsigned y,
                                             int unsigned w);
    int unsigned a;
    a = x + y * w;
    return a[15:0];
  endfunction

  // texel addresses a sample touches (ll, lr, ul, ur) and blend weights
  function automatic void footprint(input logic [23:0] s, input logic [23:0] t,
                                    output logic [15:0] ad [4], output logic [63:0] ds,
                                    output logic [63:0] dt);
    int unsigned w, h, u0, u1, v0, v1;
    logic [63:0] ps, pt;
    w = eff_dim(m_width);
    h = eff_dim(m_height);
    ps = wrap_scale(s, m_wrap_s, w);
    pt = wrap_scale(t, m_wrap_t, h);
    if (m_filter == tswf_pkg::FILTER_NEAREST) begin
      u0 = clip_idx((ps + 64'h8000) >> 16, w);
      v0 = clip_idx((pt + 64'h8000) >> 16, h);
      for (int i = 0; i < 4; i++) ad[i] = store_addr(u0, v0, w);
      ds = 0;
      dt = 0;
    end else begin
      u0 = clip_idx(ps >> 16, w);
      u1 = clip_idx((ps >> 16) + 1, w);
      v0 = clip_idx(pt >> 16, h);
      v1 = clip_idx((pt >> 16) + 1, h);
      ad[0] = store_addr(u0, v0, w);
      ad[1] = store_addr(u1, v0, w);
      ad[2] = store_addr(u0, v1, w);
      ad[3] = store_addr(u1, v1, w);
      ds = {48'd0, ps[15:0]};
      dt = {48'd0, pt[15:0]};
    end
  endfunction

  function automatic logic [63:0] chan_of(logic [23:0] tx, int ch);
    logic [7:0] by;
    by = (ch == 0) ? tx[23:16] : (ch == 1) ? tx[15:8] : tx[7:0];
    return {56'd0, by} * 257;
  endfunction

  // predicted color of one sample beat
  function automatic color_t shade_fragment(beat_t b);
    color_t      c;
    logic [15:0] ad [4];
    logic [63:0] ds, dt, lo, hi, acc, tex, frag, res;
    logic [15:0] fr [3];
    logic [15:0] outc [3];
    fr[0] = b.fr; fr[1] = b.fg; fr[2] = b.fb;
    if (b.s[23] || b.t[23]) begin
      c.r = b.fr; c.g = b.fg; c.b = b.fb; c.tx = 1'b0;
      return c;
    end
    footprint(b.s, b.t, ad, ds, dt);
    for (int ch = 0; ch < 3; ch++) begin
      if (m_filter == tswf_pkg::FILTER_NEAREST) begin
        tex = chan_of(tex_mem[ad[0]], ch);
      end else begin
        lo = chan_of(tex_mem[ad[0]], ch) * (65536 - ds) + chan_of(tex_mem[ad[1]], ch) * ds;
        hi = chan_of(tex_mem[ad[2]], ch) * (65536 - ds) + chan_of(tex_mem[ad[3]], ch) * ds;
        acc = lo * (65536 - dt) + hi * dt;
        tex = (acc + 64'h8000_0000) >> 32;
      end
      frag = {48'd0, fr[ch]};
      if (m_env == tswf_pkg::ENV_MODULATE) res = (frag * tex + 32767) / 65535;
      else if (m_env == tswf_pkg::ENV_REPLACE) res = tex;
      else res = frag;
      outc[ch] = res[15:0];
    end
    c.r = outc[0]; c.g = outc[1]; c.b = outc[2]; c.tx = 1'b1;
    return c;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, n_cycles);
    mismatches++;
  endtask

  // one beat on the input channel; model updated at acceptance
  task automatic push_beat(beat_t b, bit typed, color_t want);
    if (!quiet && $urandom_range(99) < 20) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    action = b.act; texel_index = b.idx;
    texel_red = b.rgb[23:16]; texel_green = b.rgb[15:8]; texel_blue = b.rgb[7:0];
    coord_s = b.s; coord_t = b.t;
    frag_red = b.fr; frag_green = b.fg; frag_blue = b.fb;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (b.act == tswf_pkg::ACT_WRITE) begin
      tex_mem[b.idx] = b.rgb;
      tex_written[b.idx] = 1'b1;
      n_writes++;
    end else begin
      pending_colors.push_back(typed ? want : shade_fragment(b));
      n_samples++;
    end
    @(negedge clk);
  endtask

  // a sample, preceded by writes to any texel it would read unwritten
  task automatic send_sample(beat_t b);
    logic [15:0] ad [4];
    logic [63:0] ds, dt;
    beat_t       w;
    color_t      none;
    none = '{16'd0, 16'd0, 16'd0, 1'b0};
    if (!b.s[23] && !b.t[23]) begin
      footprint(b.s, b.t, ad, ds, dt);
      for (int i = 0; i < 4; i++) begin
        if (!tex_written[ad[i]]) begin
          w = b;
          w.act = tswf_pkg::ACT_WRITE;
          w.idx = ad[i];
          w.rgb = 24'($urandom);
          push_beat(w, 1'b0, none);
        end
      end
    end
    push_beat(b, 1'b0, none);
  endtask

  // register write, only once the pipeline has drained
  task automatic set_reg(logic [tswf_pkg::CFG_IDX_W-1:0] idx,
                         logic [tswf_pkg::SIZE_W-1:0] data);
    in_valid = 1'b0;
    while (pending_colors.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tswf_pkg::CFG_FILTER: m_filter = data[0];
      tswf_pkg::CFG_WRAP_S: m_wrap_s = data[1:0];
      tswf_pkg::CFG_WRAP_T: m_wrap_t = data[1:0];
      tswf_pkg::CFG_ENV:    m_env = data[1:0];
      tswf_pkg::CFG_WIDTH:  m_width = data;
      tswf_pkg::CFG_HEIGHT: m_height = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [23:0] pick_coord();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return {1'b1, 23'($urandom)};
    if (r < 50) return 24'($urandom_range(0, 65536));
    if (r < 60) return 24'h010000;
    if (r < 68) return 24'h0;
    if (r < 85) return 24'($urandom_range(0, 4 * 65536));
    return {1'b0, 23'($urandom)};
  endfunction

  function automatic logic [15:0] pick_chan();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_cnt = 0;
    end else if (hold_cnt > 0) begin
      out_ready <= 1'b0;
      hold_cnt = hold_cnt - 1;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      hold_cnt = 90;
      hold_req = 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 17);
    end
  end

  // result checker and cycle limit
  always @(posedge clk) begin
    color_t e;
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("FAILED: results differ");
      $finish;
    end else if (!rst && out_valid && out_ready) begin
      if (pending_colors.size() == 0) begin
        report_mismatch("unexpected beat", out_red, 16'h0000);
      end else begin
        e = pending_colors.pop_front();
        n_checked++;
        if (out_red !== e.r) report_mismatch("red", out_red, e.r);
        if (out_green !== e.g) report_mismatch("green", out_green, e.g);
        if (out_blue !== e.b) report_mismatch("blue", out_blue, e.b);
        if (textured !== e.tx) report_mismatch("textured", {15'd0, textured}, {15'd0, e.tx});
      end
    end
  end

  initial begin
    beat_t  b;
    color_t none;
    logic [8:0] pw, ph;
    int     base, k;
    none = '{16'd0, 16'd0, 16'd0, 1'b0};
    // directed rows against reset settings: nearest, no wrap, pass-through, 256x256
    dir_tbl[0]  = '{'{tswf_pkg::ACT_WRITE, 16'h0000, 24'hFF0080, 24'h0, 24'h0,
                      16'h0, 16'h0, 16'h0}, none};
    dir_tbl[1]  = '{'{tswf_pkg::ACT_WRITE, 16'hFFFF, 24'h00FF01, 24'h0, 24'h0,
                      16'h0, 16'h0, 16'h0}, none};
    dir_tbl[2]  = '{'{tswf_pkg::ACT_WRITE, 16'h0001, 24'h123456, 24'h0, 24'h0,
                      16'h0, 16'h0, 16'h0}, none};
    dir_tbl[3]  = '{'{tswf_pkg::ACT_WRITE, 16'hAAAA, 24'hFFFFFF, 24'h0, 24'h0,
                      16'h0, 16'h0, 16'h0}, none};
    dir_tbl[4]  = '{'{tswf_pkg::ACT_WRITE, 16'h5555, 24'h000000, 24'h0, 24'h0,
                      16'h0, 16'h0, 16'h0}, none};
    // origin texel, color unchanged by pass-through
    dir_tbl[5]  = '{'{tswf_pkg::ACT_SAMPLE, 16'h0, 24'h0, 24'h000000, 24'h000000,
                      16'h0000, 16'hFFFF, 16'h1234}, '{16'h0000, 16'hFFFF, 16'h1234, 1'b1}};
    // largest coordinate, no wrap: index saturates to the last texel
    dir_tbl[6]  = '{'{tswf_pkg::ACT_SAMPLE, 16'h0, 24'h0, 24'h7FFFFF, 24'h7FFFFF,
                      16'hFFFF, 16'hFFFF, 16'hFFFF}, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}};
    // coordinate one lands on the last texel
    dir_tbl[7]  = '{'{tswf_pkg::ACT_SAMPLE, 16'h0, 24'h0, 24'h010000, 24'h010000,
                      16'h8000, 16'h0001, 16'hFFFE}, '{16'h8000, 16'h0001, 16'hFFFE, 1'b1}};
    // step just under one texel rounds up to texel one
    dir_tbl[8]  = '{'{tswf_pkg::ACT_SAMPLE, 16'h0, 24'h0, 24'h000101, 24'h000000,
                      16'h0101, 16'h0202, 16'h0303}, '{16'h0101, 16'h0202, 16'h0303, 1'b1}};
    // negative coordinates pass the color and clear textured
    dir_tbl[9]  = '{'{tswf_pkg::ACT_SAMPLE, 16'h0, 24'h0, 24'h800000, 24'h000000,
                      16'h0000, 16'h0000, 16'h0000}, '{16'h0000, 16'h0000, 16'h0000, 1'b0}};
    dir_tbl[10] = '{'{tswf_pkg::ACT_SAMPLE, 16'h0, 24'h0, 24'h000000, 24'hFFFFFF,
                      16'h0001, 16'h0002, 16'h0003}, '{16'h0001, 16'h0002, 16'h0003, 1'b0}};
    dir_tbl[11] = '{'{tswf_pkg::ACT_SAMPLE, 16'h0, 24'h0, 24'hFFFFFF, 24'h800000,
                      16'hFFFF, 16'h0000, 16'hFFFF}, '{16'hFFFF, 16'h0000, 16'hFFFF, 1'b0}};

    rst = 1'b1; in_valid = 1'b0; action = tswf_pkg::ACT_WRITE; texel_index = '0;
    texel_red = '0; texel_green = '0; texel_blue = '0; coord_s = '0; coord_t = '0;
    frag_red = '0; frag_green = '0; frag_blue = '0;
    cfg_valid = 1'b0; cfg_index = tswf_pkg::CFG_FILTER; cfg_data = '0;
    quiet = 1'b0; hold_req = 1'b0;
    mismatches = 0; n_samples = 0; n_writes = 0; n_checked = 0; n_cycles = 0;
    m_filter = tswf_pkg::FILTER_NEAREST; m_wrap_s = WRAP_NONE; m_wrap_t = WRAP_NONE;
    m_env = ENV_PASS; m_width = 9'd256; m_height = 9'd256;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIR_ROWS; i++)
      push_beat(dir_tbl[i].b, dir_tbl[i].b.act == tswf_pkg::ACT_SAMPLE, dir_tbl[i].want);

    // phases: fixed extremes first, then random settings
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          set_reg(tswf_pkg::CFG_FILTER, 9'(tswf_pkg::FILTER_NEAREST));
          set_reg(tswf_pkg::CFG_WRAP_S, 9'(tswf_pkg::WRAP_REPEAT));
          set_reg(tswf_pkg::CFG_WRAP_T, 9'(tswf_pkg::WRAP_CLAMP));
          set_reg(tswf_pkg::CFG_ENV, 9'(tswf_pkg::ENV_MODULATE));
          pw = 9'd4; ph = 9'd4;
        end
        1: begin
          set_reg(tswf_pkg::CFG_FILTER, 9'(FILTER_BILINEAR));
          set_reg(tswf_pkg::CFG_WRAP_S, 9'(tswf_pkg::WRAP_REPEAT));
          set_reg(tswf_pkg::CFG_WRAP_T, 9'(tswf_pkg::WRAP_REPEAT));
          set_reg(tswf_pkg::CFG_ENV, 9'(tswf_pkg::ENV_MODULATE));
          pw = 9'd8; ph = 9'd8;
        end
        2: begin
          set_reg(tswf_pkg::CFG_FILTER, 9'(FILTER_BILINEAR));
          set_reg(tswf_pkg::CFG_WRAP_S, 9'(tswf_pkg::WRAP_CLAMP));
          set_reg(tswf_pkg::CFG_WRAP_T, 9'(tswf_pkg::WRAP_CLAMP));
          set_reg(tswf_pkg::CFG_ENV, 9'(tswf_pkg::ENV_REPLACE));
          pw = 9'd1; ph = 9'd1;
        end
        3: begin
          set_reg(tswf_pkg::CFG_FILTER, 9'(FILTER_BILINEAR));
          set_reg(tswf_pkg::CFG_WRAP_S, 9'(WRAP_NONE));
          set_reg(tswf_pkg::CFG_WRAP_T, 9'(WRAP_UNUSED));
          set_reg(tswf_pkg::CFG_ENV, 9'(ENV_UNUSED));
          pw = 9'd0; ph = 9'd511;
        end
        4: begin
          set_reg(tswf_pkg::CFG_FILTER, 9'(tswf_pkg::FILTER_NEAREST));
          set_reg(tswf_pkg::CFG_WRAP_S, 9'(WRAP_UNUSED));
          set_reg(tswf_pkg::CFG_WRAP_T, 9'(WRAP_NONE));
          set_reg(tswf_pkg::CFG_ENV, 9'(tswf_pkg::ENV_REPLACE));
          pw = 9'd256; ph = 9'd256;
        end
        5: begin
          set_reg(tswf_pkg::CFG_FILTER, 9'(FILTER_BILINEAR));
          set_reg(tswf_pkg::CFG_WRAP_S, 9'(tswf_pkg::WRAP_CLAMP));
          set_reg(tswf_pkg::CFG_WRAP_T, 9'(tswf_pkg::WRAP_REPEAT));
          set_reg(tswf_pkg::CFG_ENV, 9'(tswf_pkg::ENV_MODULATE));
          pw = 9'd300; ph = 9'd3;
        end
        6: begin
          set_reg(tswf_pkg::CFG_FILTER, 9'(FILTER_BILINEAR));
          set_reg(tswf_pkg::CFG_WRAP_S, 9'(tswf_pkg::WRAP_REPEAT));
          set_reg(tswf_pkg::CFG_WRAP_T, 9'(tswf_pkg::WRAP_CLAMP));
          set_reg(tswf_pkg::CFG_ENV, 9'(tswf_pkg::ENV_MODULATE));
          pw = 9'd256; ph = 9'd2;
        end
        default: begin
          set_reg(tswf_pkg::CFG_FILTER, 9'($urandom_range(1)));
          set_reg(tswf_pkg::CFG_WRAP_S, 9'($urandom_range(3)));
          set_reg(tswf_pkg::CFG_WRAP_T, 9'($urandom_range(3)));
          set_reg(tswf_pkg::CFG_ENV, 9'($urandom_range(3)));
          pw = ($urandom_range(3) == 0) ? 9'($urandom) : 9'($urandom_range(1, 16));
          ph = ($urandom_range(3) == 0) ? 9'($urandom) : 9'($urandom_range(1, 16));
        end
      endcase
      set_reg(tswf_pkg::CFG_WIDTH, pw);
      set_reg(tswf_pkg::CFG_HEIGHT, ph);
      // one phase with no idling on either side
      quiet = (p == 3);
      // fill writes for unwritten texels count toward the phase budget
      base = n_samples + n_writes;
      k = 0;
      while (n_samples + n_writes - base < PHASE_BEATS) begin
        if (p == 8 && k == 10) hold_req = 1'b1;
        b.idx = 16'($urandom); b.rgb = 24'($urandom);
        b.s = pick_coord(); b.t = pick_coord();
        b.fr = pick_chan(); b.fg = pick_chan(); b.fb = pick_chan();
        if ($urandom_range(99) < 20) begin
          b.act = tswf_pkg::ACT_WRITE;
          if ($urandom_range(1) == 0)
            b.idx = store_addr($urandom_range(eff_dim(m_width) - 1),
                               $urandom_range(eff_dim(m_height) - 1), eff_dim(m_width));
          push_beat(b, 1'b0, none);
        end else begin
          b.act = tswf_pkg::ACT_SAMPLE;
          send_sample(b);
        end
        k++;
      end
      quiet = 1'b0;
    end

    in_valid = 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d sample beats and %0d texel writes over %0d register settings",
             n_samples, n_writes, PHASES + 1);
    $display("%0d colors compared, %0d mismatches", n_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/tswf_pkg.sv
design/tswf_ram.sv
design/tswf_coord.sv
design/tswf_filter.sv
design/texture_sampler_wrap_filter.sv
bench/testbench.sv
